[design/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// dtp_pkg
// shared types and codes for the deadline timer pool
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

	// input actions
	typedef enum logic [1:0] {
		ACT_ARM_ONE  = 2'd0,
		ACT_ARM_CONT = 2'd1,
		ACT_CANCEL   = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	// result codes
	typedef enum logic [2:0] {
		EV_ARMED   = 3'd0,
		EV_FULL    = 3'd1,
		EV_CANCEL  = 3'd2,
		EV_FIRED   = 3'd3,
		EV_NOTHING = 3'd4
	} event_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARM,
		ST_CANCEL,
		ST_DUE,
		ST_MIN,
		ST_SEL,
		ST_DIV,
		ST_PUSH,
		ST_DONE
	} state_t;

	localparam int FRAC_BITS = 10;
	localparam int CNT_W     = 4;
	localparam int PROG_W    = 11;
	localparam int SLOT_W    = 4;
	localparam int SEQ_W     = 16;
	localparam logic [PROG_W-1:0] PROG_FULL = 11'd1024;

	// one result beat, without the last flag
	typedef struct packed {
		event_t              event_res;
		logic [SLOT_W-1:0]   slot;
		logic [SEQ_W-1:0]    handle_seq;
		logic [PROG_W-1:0]   progress;
		logic                finished;
	} res_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              done;
		logic [PROG_W-1:0] quo;
	} div_sts_t;

endpackage

`default_nettype wire

[design/deadline_timer_pool_core.sv]
// ----------------------------------------------------------------------------
// deadline_timer_pool_core
// pool of timer slots with one-shot and continuous timers, fired in deadline
// order by a sequencer around a shared compare unit and a serial divider
// ----------------------------------------------------------------------------
// input channel s_axis: one beat per action (arm one-shot, arm continuous,
// cancel, tick). output channel m_axis: one result beat per arm or cancel,
// and one beat per fired timer on a tick (or one nothing-fired beat); tlast
// marks the final result beat of each action.
// an arm or cancel result beat is loaded into the output register from the
// arm or cancel state once that register is free. a tick first scans all
// SLOTS slots for due timers, then for each due slot runs a minimum search
// plus select, the divider for a continuous timer and a push (a cancelled
// due slot is freed with no push), then a last search and a final step
// that loads the last beat.
// one action is processed at a time: s_axis_tready is high only when the
// sequencer is idle. a result beat sits in the output register, so the next
// action is taken while it waits; the sequencer stalls only when it must
// write a new beat and the register is still full (m_axis_tready low).
// reset clears the in-use, cancel and continuous flags and the sequence counter; slot
// times and sequence numbers (set at arm) and due flags (set per scan) need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_pool_core #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beats
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // now[31:0], duration[63:32], cancel_slot[67:64]
	input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
	// result beats
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // slot[3:0], handle_seq[19:4], progress[30:20],
	                                        // finished[31]
	output logic [2:0]       m_axis_tuser,  // event_res[2:0]
	output logic             m_axis_tlast
);
	import dtp_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int XW = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int SW = XW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
	localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

	// slot storage
	logic [TIME_BITS-1:0] deadline_q [SLOTS];
	logic [TIME_BITS-1:0] start_q    [SLOTS];
	logic [TIME_BITS-1:0] finish_q   [SLOTS];
	logic [SEQ_W-1:0]     seq_q      [SLOTS];
	logic [SLOTS-1:0]     in_use_q;
	logic [SLOTS-1:0]     cancelled_q;
	logic [SLOTS-1:0]     cont_q;
	logic [SLOTS-1:0]     due_q;
	logic [SEQ_W-1:0]     next_seq_q;

	// latched action
	action_t              act_q;
	logic [TIME_BITS-1:0] now_q;
	logic [31:0]          dur_q;
	logic [SLOT_W-1:0]    cs_q;

	// sequencer
	state_t               state_q, state_d;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        best_q;
	logic [TIME_BITS-1:0] best_dl_q;
	logic                 found_q;
	res_t                 new_res_q;
	res_t                 pend_q;
	logic                 pend_valid_q;

	// output register
	logic                 m_valid_q;
	res_t                 m_res_q;
	logic                 m_last_q;

	logic                 out_free;
	logic                 out_load;
	res_t                 out_res;
	logic                 out_last;
	logic                 div_start;
	div_sts_t             div_sts;

	// arm helpers
	logic [SLOTS-1:0]     reclaim;
	logic [SLOTS-1:0]     use_rc;
	logic                 free_any;
	logic [IW-1:0]        free_idx;
	logic [SLOTS-1:0]     arm_bit;
	logic [SW-1:0]        sum;
	logic [TIME_BITS-1:0] end_time;
	logic                 cand;
	logic                 fin_now;

	assign out_free = !m_valid_q || m_axis_tready;

	// reclaim cancelled slots only when no slot is free
	always_comb begin
		reclaim  = (&in_use_q) ? (in_use_q & cancelled_q) : '0;
		use_rc   = in_use_q & ~reclaim;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!use_rc[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// one-hot mark of the slot taken by an arm
	assign arm_bit = free_any ? ({{(SLOTS-1){1'b0}}, 1'b1} << free_idx) : '0;

	// saturating now + duration
	assign sum      = SW'(now_q) + SW'(dur_q);
	assign end_time = (sum > {{(SW-TIME_BITS){1'b0}}, TMAX}) ? TMAX : TIME_BITS'(sum);

	// minimum search compare, one slot per cycle
	assign cand    = due_q[idx_q] && (!found_q || deadline_q[idx_q] < best_dl_q);
	assign fin_now = !(now_q < finish_q[best_q]);

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_res       = '0;
		out_last      = 1'b0;
		div_start     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (action_t'(s_axis_tuser))
						ACT_ARM_ONE,
						ACT_ARM_CONT: state_d = ST_ARM;
						ACT_CANCEL:   state_d = ST_CANCEL;
						default:      state_d = ST_DUE;
					endcase
				end
			end
			ST_ARM: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
					if (free_any) begin
						out_res.event_res  = EV_ARMED;
						out_res.slot       = SLOT_W'(free_idx);
						out_res.handle_seq = next_seq_q;
					end else begin
						out_res.event_res = EV_FULL;
					end
					state_d = ST_IDLE;
				end
			end
			ST_CANCEL: begin
				if (out_free) begin
					out_load          = 1'b1;
					out_last          = 1'b1;
					out_res.event_res = EV_CANCEL;
					out_res.slot      = cs_q;
					state_d           = ST_IDLE;
				end
			end
			ST_DUE: begin
				if (idx_q == LAST_IDX) state_d = ST_MIN;
			end
			ST_MIN: begin
				if (idx_q == LAST_IDX) state_d = ST_SEL;
			end
			ST_SEL: begin
				if (!found_q) begin
					state_d = ST_DONE;
				end else if (cancelled_q[best_q]) begin
					state_d = ST_MIN;
				end else if (cont_q[best_q]) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_DIV: begin
				if (div_sts.done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				// hold one fire back so the final one can carry last
				if (!pend_valid_q) begin
					state_d = ST_MIN;
				end else if (out_free) begin
					out_load = 1'b1;
					out_res  = pend_q;
					state_d  = ST_MIN;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
					if (pend_valid_q) out_res = pend_q;
					else              out_res.event_res = EV_NOTHING;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	dtp_div #(
		.TIME_BITS(TIME_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.elapsed(now_q - start_q[best_q]),
		.span   (finish_q[best_q] - start_q[best_q]),
		.sts    (div_sts)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
			in_use_q     <= '0;
			cancelled_q  <= '0;
			cont_q       <= '0;
			next_seq_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load)           m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;

			if (state_q == ST_DUE || state_q == ST_MIN)
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			if (state_q == ST_MIN && cand) found_q <= 1'b1;
			if (state_q == ST_SEL)         found_q <= 1'b0;

			case (state_q)
				ST_ARM: begin
					if (out_free) begin
						in_use_q    <= use_rc | arm_bit;
						cancelled_q <= cancelled_q & ~reclaim & ~arm_bit;
						cont_q      <= (cont_q & ~reclaim & ~arm_bit) |
							((act_q == ACT_ARM_CONT) ? arm_bit : '0);
						if (free_any) next_seq_q <= next_seq_q + 1'b1;
					end
				end
				ST_CANCEL: begin
					for (int i = 0; i < SLOTS; i++)
						if (int'(cs_q) == i && in_use_q[i]) cancelled_q[i] <= 1'b1;
				end
				ST_SEL: begin
					if (found_q && (cancelled_q[best_q] || !cont_q[best_q])) begin
						in_use_q[best_q]    <= 1'b0;
						cancelled_q[best_q] <= 1'b0;
						cont_q[best_q]      <= 1'b0;
					end
				end
				ST_DIV: begin
					if (div_sts.done && fin_now) begin
						in_use_q[best_q] <= 1'b0;
						cont_q[best_q]   <= 1'b0;
					end
				end
				ST_PUSH: begin
					if (!pend_valid_q) pend_valid_q <= 1'b1;
				end
				ST_DONE: begin
					if (out_free) pend_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload and slot storage
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q <= action_t'(s_axis_tuser);
			now_q <= TIME_BITS'(s_axis_tdata[31:0]);
			dur_q <= s_axis_tdata[63:32];
			cs_q  <= s_axis_tdata[67:64];
		end
		if (out_load) begin
			m_res_q  <= out_res;
			m_last_q <= out_last;
		end
		if (state_q == ST_ARM && out_free && free_any) begin
			start_q[free_idx] <= now_q;
			seq_q[free_idx]   <= next_seq_q;
			if (act_q == ACT_ARM_CONT) begin
				deadline_q[free_idx] <= now_q;
				finish_q[free_idx]   <= end_time;
			end else begin
				deadline_q[free_idx] <= end_time;
				finish_q[free_idx]   <= end_time;
			end
		end
		if (state_q == ST_DUE)
			due_q[idx_q] <= in_use_q[idx_q] && (deadline_q[idx_q] <= now_q);
		if (state_q == ST_MIN && cand) begin
			best_q    <= idx_q;
			best_dl_q <= deadline_q[idx_q];
		end
		if (state_q == ST_SEL && found_q) begin
			due_q[best_q] <= 1'b0;
			new_res_q     <= '{event_res: EV_FIRED, slot: SLOT_W'(best_q),
				handle_seq: seq_q[best_q], progress: '0, finished: 1'b1};
		end
		if (state_q == ST_DIV && div_sts.done) begin
			new_res_q <= '{event_res: new_res_q.event_res, slot: new_res_q.slot,
				handle_seq: new_res_q.handle_seq, progress: div_sts.quo,
				finished: fin_now};
			if (!fin_now) deadline_q[best_q] <= now_q;
		end
		if (state_q == ST_PUSH && (!pend_valid_q || out_free))
			pend_q <= new_res_q;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_res_q.event_res;
	assign m_axis_tdata  = {m_res_q.finished, m_res_q.progress, m_res_q.handle_seq,
		m_res_q.slot};
	assign m_axis_tlast  = m_last_q;

	// a free slot never carries a cancel mark
	a_cancel_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(cancelled_q & ~in_use_q) == '0)
		else $error("cancel mark on free slot");

	// no held-back fire survives into idle
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending result left in idle");

	// divider answers only while the sequencer waits for it
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider result outside divide state");

	// scan index rests at zero between scans
	a_idx_rest: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> idx_q == '0)
		else $error("scan index not at rest");

endmodule

`default_nettype wire

[design/dtp_div.sv]
// ----------------------------------------------------------------------------
// dtp_div
// restoring fraction divider, one quotient bit per cycle, saturates at one
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_div #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [TIME_BITS-1:0] elapsed,
	input  wire logic [TIME_BITS-1:0] span,
	output dtp_pkg::div_sts_t         sts
);
	import dtp_pkg::*;

	logic                 busy_q;
	logic                 chk_q;
	logic                 done_q;
	logic                 full_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TIME_BITS-1:0] r_q;
	logic [TIME_BITS-1:0] span_q;
	logic [FRAC_BITS-1:0] q_q;
	logic [TIME_BITS:0]   two_r;
	logic                 ge;

	assign two_r = {r_q, 1'b0};
	assign ge    = two_r >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				chk_q  <= 1'b1;
				cnt_q  <= '0;
			end else if (chk_q) begin
				chk_q <= 1'b0;
				// elapsed at or past span: complete
				if (r_q >= span_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= elapsed;
			span_q <= span;
			q_q    <= '0;
		end else if (chk_q) begin
			full_q <= r_q >= span_q;
		end else if (busy_q) begin
			if (ge) begin
				r_q <= TIME_BITS'(two_r - {1'b0, span_q});
				q_q <= {q_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				r_q <= two_r[TIME_BITS-1:0];
				q_q <= {q_q[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign sts.quo  = full_q ? PROG_FULL : PROG_W'(q_q);

endmodule

`default_nettype wire
